// ===== hdl/path_cell_projection_macros.svh =====
// Assertion macros for the path cell projection block.
// Used by the top level; they rely on clk_i and rst_ni in the including scope.
`ifndef PATH_CELL_PROJECTION_MACROS_SVH
`define PATH_CELL_PROJECTION_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that holds at every clock edge outside reset.
`define PCP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("pcp assertion failed");
// Property whose consequent holds in the cycle after the antecedent.
`define PCP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pcp assertion failed");
`else
`define PCP_ASSERT(lbl, expr)
`define PCP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/pcp_pkg.sv =====
// Shared types and constants of the path cell projection block.
// Used by pcp_div, path_cell_projection, pcp_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package pcp_pkg;

  // Command codes carried in tuser of the input stream.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [3:0] CFG_REVERSE = 4'd0;
  localparam logic [3:0] CFG_COUNT   = 4'd1;

  // One in Q1.16.
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // Divider widths: numerator, divisor and kept quotient bits.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_Q_W   = 17;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hdl/path_cell_projection.sv =====
// Top level of the path cell projection block: sequencer, shared multiplier,
// square root steps and search. Depends on pcp_pkg, pcp_ram, pcp_div, macros.
`timescale 1ns / 1ps
//
// Channel    Direction  Beat carries
// s_axis     in         load pair or project point (tuser = command)
// m_axis     out        found, error, cell index, fraction
// cfg        in         register index and write data
//
// A load beat that builds a cell runs, per edge, a square root of 32 steps
// and two 64-step divisions on the shared divider. A project beat tests
// cells edge by edge (edge RAM read, then the shared multiplier), moves on at
// the first negative edge, and on a hit divides for the fraction.
// The input is not ready while a beat is in work; a result waiting on the
// output does not stop the next beat being taken, only its hand-off. Reset needs no clearing pass.
`include "path_cell_projection_macros.svh"

module path_cell_projection #(
  parameter int MAX_CELLS     = 1024,
  parameter int SEARCH_RADIUS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pair_index[10:0], x[42:11], z[74:43], right_x[106:75], right_z[138:107],
  // full_search[139], zero fill up to 143
  input  logic [143:0] s_axis_tdata,
  // cmd[0]
  input  logic         s_axis_tuser,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // found[0], error[1], cell_index[12:2], fraction[29:13], zero fill up to 31
  output logic [31:0]  m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int IDX_W   = $clog2(MAX_CELLS);
  localparam int SLOT_W  = IDX_W + 2;
  localparam int CNT_W   = $clog2(MAX_CELLS + 1);
  localparam int OFF_W   = $clog2(SEARCH_RADIUS + 1);
  localparam int RAM_W   = 32 + 32 + 18 + 18;

  typedef enum logic [4:0] {
    ST_IDLE, ST_L_DIFF, ST_L_SHIFT, ST_L_SQX, ST_L_SQZ, ST_L_SUM, ST_L_SQRT,
    ST_L_LEN, ST_L_DIVX, ST_L_DIVZ, ST_L_WRITE, ST_L_STORE, ST_P_START,
    ST_T_ADDR, ST_T_DATA, ST_T_MX, ST_T_MZ, ST_T_SUM, ST_F_SHIFT, ST_F_DIV,
    ST_F_COMMIT, ST_DONE
  } state_e;

  typedef enum logic [1:0] {PH_PREV, PH_UP, PH_DN, PH_FULL} phase_e;

  state_e state_q;
  phase_e phase_q;

  // Configuration.
  logic        reverse_q;
  logic [10:0] cell_count_q;

  // Latched input beat and kept pair.
  logic signed [31:0] in_x_q, in_z_q, in_rx_q, in_rz_q;
  logic               in_full_q;
  logic signed [31:0] prev_lx_q, prev_lz_q, prev_rx_q, prev_rz_q;

  // Kept projection state.
  logic             last_valid_q;
  logic [IDX_W-1:0] last_idx_q;
  logic [16:0]      last_frac_q;

  // Edge build datapath.
  logic [1:0]         edge_q;
  logic signed [31:0] ax_w, az_w, bx_w, bz_w;
  logic signed [32:0] dx_w, dz_w;
  logic               dneg_x_q, dneg_z_q;
  logic [32:0]        mx_q, mz_q;
  logic [63:0]        sq_v_q, sq_r_q, sq_bit_q;
  logic [4:0]         sq_cnt_q;
  logic [63:0]        sq_rb;
  logic               len_zero_q;
  logic [16:0]        qx_q, qz_q;
  logic signed [17:0] nx_w, nz_w;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] acc_q, prod_q;

  // Cell test datapath.
  logic [IDX_W-1:0]   cand_q, up_q, dn_q, up_n, dn_n;
  logic [OFF_W-1:0]   off_q;
  logic [1:0]         j_q;
  logic signed [32:0] diffx_q, diffz_q;
  logic signed [17:0] nxr_q, nzr_q;
  logic signed [52:0] d0_q, d2_q, dsum_w;
  logic [53:0]        ft_q;
  logic [52:0]        fa_q;
  logic [16:0]        fval_q;
  logic [CNT_W-1:0]   count_w;
  logic               has_prev_w;

  // Result.
  logic        res_load_q, res_found_q, res_error_q;
  logic        out_valid_q, out_found_q, out_error_q;
  logic [10:0] out_cell_q;
  logic [16:0] out_frac_q;

  // RAM and divider.
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [RAM_W-1:0]   ram_wdata, ram_rdata;
  logic               div_start_q;
  logic [63:0]        div_num_q;
  logic [47:0]        div_den_q;
  pcp_pkg::div_req_t  div_req;
  pcp_pkg::div_rsp_t  div_rsp;

  logic s_accept;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Cells in use, clipped to the table size.
  always_comb begin
    if (32'(cell_count_q) > MAX_CELLS) begin
      count_w = CNT_W'(MAX_CELLS);
    end else begin
      count_w = CNT_W'(cell_count_q);
    end
  end

  assign has_prev_w = last_valid_q && (CNT_W'(last_idx_q) < count_w);

  // Window neighbors with wrap-around.
  assign up_n = (CNT_W'(up_q) == count_w - 1'b1) ? '0 : up_q + 1'b1;
  assign dn_n = (dn_q == '0) ? IDX_W'(count_w - 1'b1) : dn_q - 1'b1;

  // Edge endpoints for the edge being built.
  always_comb begin
    case (edge_q)
      2'd0: begin
        ax_w = prev_lx_q; az_w = prev_lz_q; bx_w = prev_rx_q; bz_w = prev_rz_q;
      end
      2'd1: begin
        ax_w = prev_rx_q; az_w = prev_rz_q; bx_w = in_rx_q; bz_w = in_rz_q;
      end
      2'd2: begin
        ax_w = in_rx_q; az_w = in_rz_q; bx_w = in_x_q; bz_w = in_z_q;
      end
      default: begin
        ax_w = in_x_q; az_w = in_z_q; bx_w = prev_lx_q; bz_w = prev_lz_q;
      end
    endcase
    dx_w = {bx_w[31], bx_w} - {ax_w[31], ax_w};
    dz_w = {bz_w[31], bz_w} - {az_w[31], az_w};
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      ST_L_SQX: begin
        mul_a = {2'b00, mx_q[30:0]};
        mul_b = {2'b00, mx_q[30:0]};
      end
      ST_L_SQZ: begin
        mul_a = {2'b00, mz_q[30:0]};
        mul_b = {2'b00, mz_q[30:0]};
      end
      ST_T_MZ: begin
        mul_a = {{15{nzr_q[17]}}, nzr_q};
        mul_b = diffz_q;
      end
      default: begin
        mul_a = {{15{nxr_q[17]}}, nxr_q};
        mul_b = diffx_q;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign sq_rb  = sq_r_q + sq_bit_q;
  assign dsum_w = 53'(acc_q + prod_q);

  // Signed normals from the quotients.
  always_comb begin
    if (len_zero_q) begin
      nx_w = '0;
      nz_w = '0;
    end else begin
      nx_w = dneg_z_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
      nz_w = dneg_x_q ? $signed({1'b0, qz_q}) : -$signed({1'b0, qz_q});
    end
  end

  assign ram_we    = (state_q == ST_L_WRITE);
  assign ram_waddr = {cand_q, edge_q};
  assign ram_wdata = {ax_w, az_w, nx_w, nz_w};
  assign ram_raddr = {cand_q, j_q};

  pcp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (4 * MAX_CELLS)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign div_req.start = div_start_q;
  assign div_req.num   = div_num_q;
  assign div_req.den   = div_den_q;

  pcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer, state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_PREV;
      reverse_q    <= 1'b0;
      cell_count_q <= 11'd20;
      prev_lx_q    <= '0;
      prev_lz_q    <= '0;
      prev_rx_q    <= '0;
      prev_rz_q    <= '0;
      last_valid_q <= 1'b0;
      last_idx_q   <= '0;
      last_frac_q  <= '0;
      res_load_q   <= 1'b0;
      res_found_q  <= 1'b0;
      res_error_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      div_start_q  <= 1'b0;
      edge_q       <= '0;
      j_q          <= '0;
      sq_cnt_q     <= '0;
      off_q        <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // Register writes.
      if (cfg_valid_i) begin
        case (cfg_index_i)
          pcp_pkg::CFG_REVERSE: reverse_q    <= cfg_data_i[0];
          pcp_pkg::CFG_COUNT:   cell_count_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            res_load_q  <= 1'b0;
            res_found_q <= 1'b0;
            res_error_q <= 1'b0;
            edge_q      <= '0;
            j_q         <= '0;
            if (s_axis_tuser == pcp_pkg::CMD_LOAD) begin
              if (s_axis_tdata[10:0] != 11'd0 &&
                  32'(s_axis_tdata[10:0]) - 32'd1 < MAX_CELLS) begin
                state_q <= ST_L_DIFF;
              end else begin
                state_q <= ST_L_STORE;
              end
            end else begin
              state_q <= ST_P_START;
            end
          end
        end

        // Edge build.
        ST_L_DIFF:  state_q <= ST_L_SHIFT;
        ST_L_SHIFT: begin
          if (mx_q[32:31] == 2'b00 && mz_q[32:31] == 2'b00) begin
            state_q <= ST_L_SQX;
          end
        end
        ST_L_SQX: state_q <= ST_L_SQZ;
        ST_L_SQZ: state_q <= ST_L_SUM;
        ST_L_SUM: begin
          sq_cnt_q <= 5'd31;
          state_q  <= ST_L_SQRT;
        end
        ST_L_SQRT: begin
          if (sq_cnt_q == '0) begin
            state_q <= ST_L_LEN;
          end else begin
            sq_cnt_q <= sq_cnt_q - 1'b1;
          end
        end
        ST_L_LEN: begin
          if (sq_r_q == '0) begin
            state_q <= ST_L_WRITE;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= ST_L_DIVX;
          end
        end
        ST_L_DIVX: begin
          if (div_rsp.done) begin
            div_start_q <= 1'b1;
            state_q     <= ST_L_DIVZ;
          end
        end
        ST_L_DIVZ: begin
          if (div_rsp.done) begin
            state_q <= ST_L_WRITE;
          end
        end
        ST_L_WRITE: begin
          if (edge_q == 2'd3) begin
            state_q <= ST_L_STORE;
          end else begin
            edge_q  <= edge_q + 1'b1;
            state_q <= ST_L_DIFF;
          end
        end
        ST_L_STORE: begin
          prev_lx_q  <= in_x_q;
          prev_lz_q  <= in_z_q;
          prev_rx_q  <= in_rx_q;
          prev_rz_q  <= in_rz_q;
          res_load_q <= 1'b1;
          state_q    <= ST_DONE;
        end

        // Search start.
        ST_P_START: begin
          if (reverse_q && !has_prev_w) begin
            res_error_q <= 1'b1;
            state_q     <= ST_DONE;
          end else if (count_w == '0) begin
            state_q <= ST_DONE;
          end else if (has_prev_w) begin
            phase_q <= PH_PREV;
            off_q   <= '0;
            state_q <= ST_T_ADDR;
          end else if (in_full_q) begin
            phase_q <= PH_FULL;
            state_q <= ST_T_ADDR;
          end else begin
            state_q <= ST_DONE;
          end
        end

        // One edge test.
        ST_T_ADDR: state_q <= ST_T_DATA;
        ST_T_DATA: state_q <= ST_T_MX;
        ST_T_MX:   state_q <= ST_T_MZ;
        ST_T_MZ:   state_q <= ST_T_SUM;
        ST_T_SUM: begin
          if (dsum_w < 0) begin
            j_q     <= '0;
            state_q <= ST_T_ADDR;
            case (phase_q)
              PH_PREV: phase_q <= PH_UP;
              PH_UP:   phase_q <= PH_DN;
              PH_DN: begin
                if (32'(off_q) + 32'd1 < SEARCH_RADIUS) begin
                  off_q   <= off_q + 1'b1;
                  phase_q <= PH_UP;
                end else if (in_full_q) begin
                  phase_q <= PH_FULL;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              default: begin
                if (CNT_W'(cand_q) + 1'b1 >= count_w) begin
                  state_q <= ST_DONE;
                end
              end
            endcase
          end else if (j_q == 2'd3) begin
            state_q <= ST_F_SHIFT;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_T_ADDR;
          end
        end

        // Fraction.
        ST_F_SHIFT: begin
          if (ft_q[53:47] == '0) begin
            if (ft_q == '0) begin
              state_q <= ST_F_COMMIT;
            end else begin
              div_start_q <= 1'b1;
              state_q     <= ST_F_DIV;
            end
          end
        end
        ST_F_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_F_COMMIT;
          end
        end
        ST_F_COMMIT: begin
          last_valid_q <= 1'b1;
          last_idx_q   <= reverse_q ? IDX_W'(count_w - 1'b1 - CNT_W'(cand_q)) : cand_q;
          last_frac_q  <= reverse_q ? (pcp_pkg::FRAC_ONE - fval_q) : fval_q;
          res_found_q  <= 1'b1;
          state_q      <= ST_DONE;
        end

        // Hand the result to the output register.
        ST_DONE: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          in_x_q    <= s_axis_tdata[42:11];
          in_z_q    <= s_axis_tdata[74:43];
          in_rx_q   <= s_axis_tdata[106:75];
          in_rz_q   <= s_axis_tdata[138:107];
          in_full_q <= s_axis_tdata[139];
          cand_q    <= IDX_W'(32'(s_axis_tdata[10:0]) - 32'd1);
        end
      end
      ST_L_DIFF: begin
        dneg_x_q <= dx_w[32];
        dneg_z_q <= dz_w[32];
        mx_q     <= dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
        mz_q     <= dz_w[32] ? 33'(-dz_w) : 33'(dz_w);
      end
      ST_L_SHIFT: begin
        if (mx_q[32:31] != 2'b00 || mz_q[32:31] != 2'b00) begin
          mx_q <= mx_q >> 1;
          mz_q <= mz_q >> 1;
        end
      end
      ST_L_SQX: prod_q <= mul_p;
      ST_L_SQZ: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_L_SUM: begin
        sq_v_q   <= 64'(acc_q + prod_q);
        sq_r_q   <= '0;
        sq_bit_q <= 64'h4000_0000_0000_0000;
      end
      // One square root step.
      ST_L_SQRT: begin
        if (sq_v_q >= sq_rb) begin
          sq_v_q <= sq_v_q - sq_rb;
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      ST_L_LEN: begin
        len_zero_q <= (sq_r_q == '0);
        div_num_q  <= ({31'd0, mz_q[30:0], 2'b00} << 14) + {33'd0, sq_r_q[31:1]};
        div_den_q  <= 48'(sq_r_q[31:0]);
      end
      ST_L_DIVX: begin
        if (div_rsp.done) begin
          qx_q      <= div_rsp.quot;
          div_num_q <= ({31'd0, mx_q[30:0], 2'b00} << 14) + {33'd0, sq_r_q[31:1]};
        end
      end
      ST_L_DIVZ: begin
        if (div_rsp.done) begin
          qz_q <= div_rsp.quot;
        end
      end
      ST_P_START: begin
        if (has_prev_w) begin
          cand_q <= reverse_q ? IDX_W'(count_w - 1'b1 - CNT_W'(last_idx_q)) : last_idx_q;
          up_q   <= reverse_q ? IDX_W'(count_w - 1'b1 - CNT_W'(last_idx_q)) : last_idx_q;
          dn_q   <= reverse_q ? IDX_W'(count_w - 1'b1 - CNT_W'(last_idx_q)) : last_idx_q;
        end else begin
          cand_q <= '0;
        end
      end
      ST_T_DATA: begin
        diffx_q <= {in_x_q[31], in_x_q} - {ram_rdata[99], ram_rdata[99:68]};
        diffz_q <= {in_z_q[31], in_z_q} - {ram_rdata[67], ram_rdata[67:36]};
        nxr_q   <= ram_rdata[35:18];
        nzr_q   <= ram_rdata[17:0];
      end
      ST_T_MX: prod_q <= mul_p;
      ST_T_MZ: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ST_T_SUM: begin
        if (j_q == 2'd0) begin
          d0_q <= dsum_w;
        end
        if (j_q == 2'd2) begin
          d2_q <= dsum_w;
        end
        if (dsum_w < 0) begin
          // Pick the next cell of the search order.
          case (phase_q)
            PH_PREV: cand_q <= up_q;
            PH_UP:   cand_q <= dn_q;
            PH_DN: begin
              if (32'(off_q) + 32'd1 < SEARCH_RADIUS) begin
                up_q   <= up_n;
                dn_q   <= dn_n;
                cand_q <= up_n;
              end else begin
                cand_q <= '0;
              end
            end
            default: cand_q <= cand_q + 1'b1;
          endcase
        end else if (j_q == 2'd3) begin
          fa_q <= 53'(d0_q);
          ft_q <= 54'(d0_q) + 54'(d2_q);
        end
      end
      ST_F_SHIFT: begin
        if (ft_q[53:47] != '0) begin
          fa_q <= fa_q >> 1;
          ft_q <= ft_q >> 1;
        end else begin
          fval_q    <= '0;
          div_num_q <= ({11'd0, fa_q} << 16) + {11'd0, ft_q[53:1]};
          div_den_q <= ft_q[47:0];
        end
      end
      ST_F_DIV: begin
        if (div_rsp.done) begin
          fval_q <= div_rsp.quot;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_found_q <= res_found_q;
          out_error_q <= res_error_q;
          if (res_load_q) begin
            out_cell_q <= '0;
            out_frac_q <= '0;
          end else begin
            out_cell_q <= last_valid_q ? 11'({1'b0, last_idx_q}) : 11'h7FF;
            out_frac_q <= last_frac_q;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_frac_q, out_cell_q, out_error_q, out_found_q};

  // A pending result never claims both a hit and an error.
  `PCP_ASSERT(a_found_error_excl, m_axis_tvalid |-> !(out_found_q && out_error_q))
  // An error result only comes out of reverse mode.
  `PCP_ASSERT(a_error_reverse, (m_axis_tvalid && out_error_q) |-> reverse_q)
  // An accepted beat keeps the input closed in the next cycle.
  `PCP_ASSERT_NEXT(a_busy_after_beat, s_accept, !s_axis_tready)

endmodule

// ===== hdl/pcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the edge table of the path cell projection block.
`timescale 1ns / 1ps

module pcp_ram #(
  parameter int WIDTH = 100,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pcp_div.sv =====
// Restoring divider, one quotient bit per cycle, with round-free truncation.
// Depends on pcp_pkg for its widths and request/response structs.
`timescale 1ns / 1ps

module pcp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcp_pkg::div_req_t req_i,
  output pcp_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(pcp_pkg::DIV_NUM_W);

  logic [pcp_pkg::DIV_DEN_W:0]   rem_q;
  logic [pcp_pkg::DIV_NUM_W-1:0] quot_q;
  logic [pcp_pkg::DIV_DEN_W-1:0] den_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q;
  logic                          done_q;

  logic [pcp_pkg::DIV_DEN_W:0] rem_sh;
  logic [pcp_pkg::DIV_DEN_W:0] rem_nx;
  logic                        ge;

  // One shift-and-subtract step.
  always_comb begin
    rem_sh = {rem_q[pcp_pkg::DIV_DEN_W-1:0], quot_q[pcp_pkg::DIV_NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  // Sequencing of the steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(pcp_pkg::DIV_NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quot_q <= req_i.num;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= rem_nx;
      quot_q <= {quot_q[pcp_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q[pcp_pkg::DIV_Q_W-1:0];

endmodule

// ===== sim/pcp_checker.sv =====
// Scoreboard for the path cell projection block: watches the stream and config channels.
// Holds its own copy of the cell memory and search logic. Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_checker #(
  parameter int MAX_CELLS     = 1024,
  parameter int SEARCH_RADIUS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [143:0] s_tdata_i,
  input  logic         s_tuser_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [31:0]  m_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [3:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           found_count_o,
  output int           rev_error_count_o
);

  localparam int SLOTS = 4 * MAX_CELLS;

  typedef struct packed {
    logic        found;
    logic        err;
    logic [10:0] cidx;
    logic [16:0] frac;
  } outcome_t;

  // Shadow of the registers and of the block's state.
  logic        shadow_rev;
  int          shadow_count;
  longint      pl_x, pl_z, pr_x, pr_z;
  int          anc_x [SLOTS];
  int          anc_z [SLOTS];
  int          nrm_x [SLOTS];
  int          nrm_z [SLOTS];
  int          held_cell;
  logic [16:0] held_frac;

  outcome_t awaited[$];
  outcome_t want, got;

  // Bitwise integer square root, rounded down.
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Anchor and unit inward normal of the edge from a to b.
  function automatic void build_edge(int slot, longint ax, longint az, longint bx, longint bz);
    longint      dx, dz;
    logic [63:0] mx, mz, len, qx, qz;
    int          nx, nz;
    dx = bx - ax;
    dz = bz - az;
    mx = (dx < 0) ? -dx : dx;
    mz = (dz < 0) ? -dz : dz;
    nx = 0;
    nz = 0;
    while (mx >= 64'h8000_0000 || mz >= 64'h8000_0000) begin
      mx = mx >> 1;
      mz = mz >> 1;
    end
    len = isqrt(mx * mx + mz * mz);
    if (len != 0) begin
      qx = ((mz << 16) + len / 2) / len;
      qz = ((mx << 16) + len / 2) / len;
      nx = (dz < 0) ? -int'(qx) : int'(qx);
      nz = (dx < 0) ? int'(qz) : -int'(qz);
    end
    anc_x[slot] = int'(ax);
    anc_z[slot] = int'(az);
    nrm_x[slot] = nx;
    nrm_z[slot] = nz;
  endfunction

  // A point is inside when no edge distance is negative.
  function automatic bit cell_holds(int cidx, longint px, longint pz,
                                    output longint d0, output longint d2);
    longint dj;
    int     s;
    bit     ok;
    ok = 1'b1;
    d0 = 0;
    d2 = 0;
    for (int j = 0; j < 4; j++) begin
      s  = (cidx * 4 + j) % SLOTS;
      dj = longint'(nrm_x[s]) * (px - longint'(anc_x[s]))
         + longint'(nrm_z[s]) * (pz - longint'(anc_z[s]));
      if (j == 0) d0 = dj;
      if (j == 2) d2 = dj;
      if (dj < 0) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [16:0] frac_of(longint d0, longint d2);
    logic [63:0] a, t;
    a = d0;
    t = a + d2;
    while (t >= 64'h0000_8000_0000_0000) begin
      a = a >> 1;
      t = t >> 1;
    end
    if (t == 0) return '0;
    return 17'(((a << 16) + t / 2) / t);
  endfunction

  // Expected result of one input beat; updates the shadow state.
  function automatic outcome_t predict_beat(logic cmd, logic [143:0] d);
    outcome_t    o;
    longint      px, pz, rx, rz, cnt, prev, n, cand, d0, d2;
    int          pidx, base;
    bit          has_prev, hit, full;
    logic [16:0] f;
    o    = '0;
    pidx = d[10:0];
    px   = longint'($signed(d[42:11]));
    pz   = longint'($signed(d[74:43]));
    rx   = longint'($signed(d[106:75]));
    rz   = longint'($signed(d[138:107]));
    full = d[139];
    if (cmd == pcp_pkg::CMD_LOAD) begin
      if (pidx > 0 && pidx - 1 < MAX_CELLS) begin
        base = (pidx - 1) * 4;
        build_edge(base + 0, pl_x, pl_z, pr_x, pr_z);
        build_edge(base + 1, pr_x, pr_z, rx, rz);
        build_edge(base + 2, rx, rz, px, pz);
        build_edge(base + 3, px, pz, pl_x, pl_z);
      end
      pl_x = px;
      pl_z = pz;
      pr_x = rx;
      pr_z = rz;
      return o;
    end
    cnt      = (shadow_count > MAX_CELLS) ? MAX_CELLS : shadow_count;
    has_prev = held_cell >= 0 && held_cell < cnt;
    hit      = 1'b0;
    cand     = -1;
    d0       = 0;
    d2       = 0;
    if (shadow_rev && !has_prev) begin
      o.err = 1'b1;
    end else if (cnt > 0) begin
      // Previous cell first, then the window around it with wrap-around.
      if (has_prev) begin
        prev = shadow_rev ? cnt - held_cell - 1 : held_cell;
        hit  = cell_holds(int'(prev), px, pz, d0, d2);
        if (hit) cand = prev;
        for (int off = 0; !hit && off < SEARCH_RADIUS; off++) begin
          n = (prev + off) % cnt;
          if (cell_holds(int'(n), px, pz, d0, d2)) begin
            cand = n;
            hit  = 1'b1;
          end else begin
            n = ((prev - off) % cnt + cnt) % cnt;
            if (cell_holds(int'(n), px, pz, d0, d2)) begin
              cand = n;
              hit  = 1'b1;
            end
          end
        end
      end
      if (!hit && full) begin
        for (longint i = 0; !hit && i < cnt; i++) begin
          if (cell_holds(int'(i), px, pz, d0, d2)) begin
            cand = i;
            hit  = 1'b1;
          end
        end
      end
      if (hit) begin
        f         = frac_of(d0, d2);
        held_cell = shadow_rev ? int'(cnt - cand - 1) : int'(cand);
        held_frac = shadow_rev ? pcp_pkg::FRAC_ONE - f : f;
        o.found   = 1'b1;
      end
    end
    o.cidx = held_cell[10:0];
    o.frac = held_frac;
    return o;
  endfunction

  // Monitor: config writes, accepted input beats and result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_rev        = 1'b0;
      shadow_count      = 20;
      pl_x              = 0;
      pl_z              = 0;
      pr_x              = 0;
      pr_z              = 0;
      held_cell         = -1;
      held_frac         = '0;
      awaited.delete();
      fail_count_o      = 0;
      pending_o         = 0;
      found_count_o     = 0;
      rev_error_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pcp_pkg::CFG_REVERSE: shadow_rev = cfg_data_i[0];
          pcp_pkg::CFG_COUNT:   shadow_count = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        want = predict_beat(s_tuser_i, s_tdata_i);
        if (want.found) found_count_o++;
        if (want.err) rev_error_count_o++;
        awaited.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.found = m_tdata_i[0];
        got.err   = m_tdata_i[1];
        got.cidx  = m_tdata_i[12:2];
        got.frac  = m_tdata_i[29:13];
        if (awaited.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result beat with nothing expected: %h", $realtime, m_tdata_i);
          fail_count_o++;
        end else begin
          want = awaited.pop_front();
          if (got.found !== want.found || got.err !== want.err ||
              got.cidx !== want.cidx || got.frac !== want.frac) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch found %b/%b error %b/%b cell %0d/%0d frac %0d/%0d",
                       $realtime, want.found, got.found, want.err, got.err,
                       $signed(want.cidx), $signed(got.cidx), want.frac, got.frac);
            fail_count_o++;
          end
        end
      end
      pending_o = awaited.size();
    end
  end

endmodule

// ===== sim/tb_path_cell_projection.sv =====
// Testbench top for the path cell projection block: clock, reset, stimulus and verdict.
// Depends on pcp_pkg, path_cell_projection and pcp_checker.
`timescale 1ns / 1ps

module tb_path_cell_projection;

  localparam logic [3:0] CFG_UNUSED = 4'hF;
  localparam int         NCELL_MAX  = 1024;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic [143:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [3:0]   cfg_index_i   = '0;
  logic [15:0]  cfg_data_i    = '0;

  int fail_count, pending, found_count, rev_error_count;
  int idle_pct = 25;
  int n_loads  = 0;
  int n_points = 0;

  // Strip geometry of the last laid path: x of each pair and the half width.
  int sx [NCELL_MAX + 1];
  int half_w;

  path_cell_projection uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pcp_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_tdata_i         (s_axis_tdata),
    .s_tuser_i         (s_axis_tuser),
    .s_tvalid_i        (s_axis_tvalid),
    .s_tready_i        (s_axis_tready),
    .m_tdata_i         (m_axis_tdata),
    .m_tvalid_i        (m_axis_tvalid),
    .m_tready_i        (m_axis_tready),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .found_count_o     (found_count),
    .rev_error_count_o (rev_error_count)
  );

  always #5 clk_i = ~clk_i;

  // Result side stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Present one beat after a random gap; valid stays high until the caller lowers it.
  task automatic send_beat(logic cmd, logic [10:0] pidx, logic [31:0] x, logic [31:0] z,
                           logic [31:0] rx, logic [31:0] rz, logic full);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, full, rz, rx, z, x, pidx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == pcp_pkg::CMD_LOAD) n_loads++;
    else n_points++;
  endtask

  task automatic send_point(int x, int z, logic full);
    send_beat(pcp_pkg::CMD_PROJECT, 11'($urandom), x, z, $urandom, $urandom, full);
  endtask

  // Drain: wait until every result is back, then a short pause.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [3:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(logic [15:0] rev_word, logic [15:0] count_word);
    settle();
    cfg_write(pcp_pkg::CFG_REVERSE, rev_word);
    cfg_write(pcp_pkg::CFG_COUNT, count_word);
    cfg_valid_i <= 1'b0;
  endtask

  // Lay a straight strip of cells along x; pairs 0 and 1 share x, so cell 0 has no width.
  task automatic lay_strip(int npairs);
    int step, x0, w;
    step   = $urandom_range(1 << 20, 1 << 16);
    half_w = $urandom_range(1 << 22, 1 << 16);
    x0     = -(1 << 30) + int'($urandom_range(1 << 28));
    for (int k = 0; k < npairs; k++) begin
      sx[k] = (k <= 1) ? x0 : x0 + (k - 1) * step;
      w     = $urandom_range(half_w, half_w / 2);
      send_beat(pcp_pkg::CMD_LOAD, 11'(k), sx[k], -w, sx[k], w, $urandom_range(1));
    end
  endtask

  // Random point inside cell c of the strip, now and then right on its ends.
  task automatic point_in(int c, logic full);
    int r, px, pz;
    r  = $urandom_range(19);
    px = (r == 0) ? sx[c] : (r == 1) ? sx[c + 1] : sx[c] + int'($urandom_range(sx[c + 1] - sx[c]));
    pz = int'($urandom_range(half_w / 2)) - half_w / 4;
    send_point(px, pz, full);
  endtask

  // One setting: optional new strip, then a walk along it mixed with jumps and noise.
  task automatic run_phase(logic rev, logic [15:0] count_word, int npairs, int npoints,
                           int full_pct);
    int eff, walk, r;
    configure({15'h7FFF, rev}, count_word);
    if (npairs > 0) lay_strip(npairs);
    eff = (count_word[10:0] > NCELL_MAX) ? NCELL_MAX : count_word[10:0];
    if (eff >= 2) begin
      // Land in the last cell, so the window wraps to the zero-width cell next.
      point_in(eff - 1, 1'b1);
      send_point(sx[0], 0, 1'b1);
    end
    walk = (eff > 0) ? $urandom_range(eff - 1) : 0;
    repeat (npoints) begin
      r = $urandom_range(99);
      if (eff > 0 && r < 70) begin
        walk = (walk + int'($urandom_range(6)) - 3 + eff) % eff;
        point_in(walk, $urandom_range(1));
      end else if (eff > 0 && r < 85) begin
        walk = $urandom_range(eff - 1);
        point_in(walk, ($urandom_range(99) < full_pct * 2));
      end else begin
        send_point($urandom, $urandom, ($urandom_range(99) < full_pct));
      end
    end
  endtask

  initial begin
    #1s;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reverse with no previous cell, register extremes and an unused index.
    cfg_write(pcp_pkg::CFG_REVERSE, 16'hFFFF);
    cfg_write(pcp_pkg::CFG_COUNT, 16'hF814);
    cfg_write(CFG_UNUSED, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    send_point(0, 0, 1'b0);
    configure(16'hFFFE, 16'h0002);
    send_point(0, 0, 1'b0);

    // Extreme coordinates, a repeated pair and a pair beyond the cell memory.
    send_beat(pcp_pkg::CMD_LOAD, 11'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 1'b1);
    send_beat(pcp_pkg::CMD_LOAD, 11'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 1'b0);
    send_beat(pcp_pkg::CMD_LOAD, 11'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 1'b1);
    send_beat(pcp_pkg::CMD_LOAD, 11'h7FF, $urandom, $urandom, $urandom, $urandom, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_point($urandom, $urandom, 1'b1);
    configure(16'h0001, 16'h0002);
    send_point(0, 0, 1'b1);
    send_point($urandom, $urandom, 1'b1);
    configure(16'h0000, 16'h0000);
    send_point(0, 0, 1'b1);

    // Random part; the first setting runs without any idling.
    idle_pct = 0;
    run_phase(1'b0, 16'd20, 21, 200, 50);
    idle_pct = 25;
    run_phase(1'b1, 16'd37, 38, 200, 50);
    run_phase(1'b0, 16'd1024, 1025, 150, 3);
    run_phase(1'b1, 16'h07FF, 0, 100, 3);
    run_phase(1'b0, 16'd0, 0, 10, 100);
    run_phase(1'b0, 16'd20, 0, 100, 50);

    settle();
    repeat (100) @(posedge clk_i);
    $display("Covered %0d boundary loads and %0d point projections over six register settings.",
             n_loads, n_points);
    $display("%0d projections landed in a cell, %0d hit reverse mode with no previous cell.",
             found_count, rev_error_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
